FILE: rtl/sccb_pkg.sv
package sccb_pkg;

   localparam int unsigned TimerWidth = 10;
   localparam int unsigned LimitWidth = 4;
   localparam int unsigned StepWidth  = 4;
   localparam int unsigned CsrWidth   = 10;

   localparam logic [1:0] ModeTick  = 2'd0;
   localparam logic [1:0] ModeWrite = 2'd1;
   localparam logic [1:0] ModeRead  = 2'd2;

   localparam logic CsrAttemptLimit = 1'b0;
   localparam logic CsrTicksPerPhase = 1'b1;

   localparam logic [LimitWidth-1:0] AttemptLimitReset = 4'd10;
   localparam logic [TimerWidth-1:0] TicksPerPhaseReset = 10'd1;

   localparam logic [StepWidth-1:0] WritePlanLength = 4'd8;
   localparam logic [StepWidth-1:0] ReadPlanLength  = 4'd12;

   typedef enum logic [2:0] {
      SegStart,
      SegSend,
      SegAck,
      SegStop,
      SegGet,
      SegNack
   } seg_kind_type;

   typedef enum logic [1:0] {
      PickDevWrite,
      PickRegister,
      PickData,
      PickDevRead
   } pick_type;

   typedef struct packed {
      seg_kind_type kind;
      pick_type     pick;
   } seg_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [6:0] device_address;
      logic [7:0] register_address;
      logic [7:0] write_data;
      logic       sda_level;
   } req_type;

   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [1:0] nack_count;
      logic [7:0] read_result;
   } rsp_type;

   typedef struct packed {
      logic [StepWidth-1:0]  step;
      logic [TimerWidth-1:0] timer;
      logic [3:0]            bit_cnt;
      logic [7:0]            shift_byte;
      logic [LimitWidth-1:0] attempts_left;
      logic [1:0]            nack_tally;
      logic [7:0]            received_byte;
      logic [6:0]            device_address;
      logic [7:0]            register_address;
      logic [7:0]            write_data;
      logic                  is_read;
   } state_type;

   typedef struct packed {
      logic [LimitWidth-1:0] attempt_limit;
      logic [TimerWidth-1:0] ticks_per_phase;
   } cfg_type;

   function automatic seg_type plan_entry(input logic is_read, input logic [StepWidth-1:0] idx);
      seg_type seg;
      seg = '{kind: SegStart, pick: PickDevWrite};
      if (is_read) begin
         case (idx)
            4'd0:    seg = '{kind: SegStart, pick: PickDevWrite};
            4'd1:    seg = '{kind: SegSend,  pick: PickDevWrite};
            4'd2:    seg = '{kind: SegAck,   pick: PickDevWrite};
            4'd3:    seg = '{kind: SegSend,  pick: PickRegister};
            4'd4:    seg = '{kind: SegAck,   pick: PickDevWrite};
            4'd5:    seg = '{kind: SegStop,  pick: PickDevWrite};
            4'd6:    seg = '{kind: SegStart, pick: PickDevWrite};
            4'd7:    seg = '{kind: SegSend,  pick: PickDevRead};
            4'd8:    seg = '{kind: SegAck,   pick: PickDevWrite};
            4'd9:    seg = '{kind: SegGet,   pick: PickDevWrite};
            4'd10:   seg = '{kind: SegNack,  pick: PickDevWrite};
            4'd11:   seg = '{kind: SegStop,  pick: PickDevWrite};
            default: seg = '{kind: SegStart, pick: PickDevWrite};
         endcase
      end else begin
         case (idx)
            4'd0:    seg = '{kind: SegStart, pick: PickDevWrite};
            4'd1:    seg = '{kind: SegSend,  pick: PickDevWrite};
            4'd2:    seg = '{kind: SegAck,   pick: PickDevWrite};
            4'd3:    seg = '{kind: SegSend,  pick: PickRegister};
            4'd4:    seg = '{kind: SegAck,   pick: PickDevWrite};
            4'd5:    seg = '{kind: SegSend,  pick: PickData};
            4'd6:    seg = '{kind: SegAck,   pick: PickDevWrite};
            4'd7:    seg = '{kind: SegStop,  pick: PickDevWrite};
            default: seg = '{kind: SegStart, pick: PickDevWrite};
         endcase
      end
      return seg;
   endfunction

   function automatic logic [4:0] phase_count(input seg_kind_type kind);
      logic [4:0] count;
      case (kind)
         SegStart: count = 5'd2;
         SegSend:  count = 5'd16;
         SegAck:   count = 5'd2;
         SegStop:  count = 5'd2;
         SegGet:   count = 5'd16;
         SegNack:  count = 5'd4;
         default:  count = 5'd2;
      endcase
      return count;
   endfunction

endpackage

FILE: rtl/sccb_chan_if.sv
interface sccb_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

FILE: rtl/sccb_step.sv
module sccb_step (
   input  sccb_pkg::state_type cur,
   input  sccb_pkg::cfg_type   cfg,
   input  sccb_pkg::req_type   req,
   output sccb_pkg::state_type nxt,
   output sccb_pkg::rsp_type   res
);

   always_comb begin
      logic                               start;
      logic [sccb_pkg::StepWidth-1:0]     idx;
      logic [sccb_pkg::StepWidth-1:0]     plan_len;
      sccb_pkg::seg_type                  seg;
      sccb_pkg::seg_type                  nseg;
      logic [3:0]                         p;
      logic [sccb_pkg::TimerWidth-1:0]    tpp;
      logic [sccb_pkg::LimitWidth-1:0]    attempts;

      nxt = cur;
      res = '{scl: 1'b1, sda_out: 1'b1, sda_drive: 1'b1, busy_res: 1'b0, done_res: 1'b0,
              nack_count: 2'd0, read_result: 8'd0};
      idx = '0;
      seg = '{kind: sccb_pkg::SegStart, pick: sccb_pkg::PickDevWrite};
      nseg = seg;
      p = 4'd0;
      tpp = (cfg.ticks_per_phase == '0) ? sccb_pkg::TimerWidth'(1) : cfg.ticks_per_phase;
      attempts = '0;

      start = (cur.step == '0) &&
              (req.mode == sccb_pkg::ModeWrite || req.mode == sccb_pkg::ModeRead);
      if (start) begin
         nxt.is_read = (req.mode == sccb_pkg::ModeRead);
         nxt.device_address = req.device_address;
         nxt.register_address = req.register_address;
         nxt.write_data = req.write_data;
         nxt.attempts_left = (cfg.attempt_limit == '0) ? sccb_pkg::LimitWidth'(1)
                                                       : cfg.attempt_limit;
         nxt.nack_tally = 2'd0;
         nxt.step = sccb_pkg::StepWidth'(1);
         nxt.bit_cnt = 4'd0;
         nxt.timer = '0;
      end

      plan_len = nxt.is_read ? sccb_pkg::ReadPlanLength : sccb_pkg::WritePlanLength;

      if (nxt.step != '0) begin
         idx = nxt.step - sccb_pkg::StepWidth'(1);
         seg = sccb_pkg::plan_entry(nxt.is_read, idx);
         p = nxt.bit_cnt;
         res.busy_res = 1'b1;
         case (seg.kind)
            sccb_pkg::SegStart: begin
               res.scl = 1'b1;
               res.sda_out = (p == 4'd0);
            end
            sccb_pkg::SegSend: begin
               res.scl = p[0];
               res.sda_out = nxt.shift_byte[7];
            end
            sccb_pkg::SegAck, sccb_pkg::SegGet: begin
               res.scl = p[0];
               res.sda_out = 1'b0;
               res.sda_drive = 1'b0;
            end
            sccb_pkg::SegStop: begin
               res.scl = (p != 4'd0);
               res.sda_out = (p != 4'd0);
            end
            default: begin
               res.scl = (p == 4'd2);
               res.sda_out = 1'b1;
            end
         endcase

         if ({1'b0, nxt.timer} + 11'd1 < {1'b0, tpp}) begin
            nxt.timer = nxt.timer + sccb_pkg::TimerWidth'(1);
         end else begin
            nxt.timer = '0;
            if (seg.kind == sccb_pkg::SegAck && p == 4'd1 && req.sda_level &&
                nxt.nack_tally != 2'd3) begin
               nxt.nack_tally = nxt.nack_tally + 2'd1;
            end
            if (seg.kind == sccb_pkg::SegSend && p[0]) begin
               nxt.shift_byte = {nxt.shift_byte[6:0], 1'b0};
            end
            if (seg.kind == sccb_pkg::SegGet && p[0]) begin
               nxt.shift_byte = {nxt.shift_byte[6:0], req.sda_level};
            end
            if ({1'b0, p} + 5'd1 < sccb_pkg::phase_count(seg.kind)) begin
               nxt.bit_cnt = p + 4'd1;
            end else begin
               if (seg.kind == sccb_pkg::SegGet) begin
                  nxt.received_byte = nxt.shift_byte;
               end
               if (idx + sccb_pkg::StepWidth'(1) < plan_len) begin
                  nseg = sccb_pkg::plan_entry(nxt.is_read, idx + sccb_pkg::StepWidth'(1));
                  nxt.step = idx + sccb_pkg::StepWidth'(2);
                  nxt.bit_cnt = 4'd0;
                  if (nseg.kind == sccb_pkg::SegSend) begin
                     case (nseg.pick)
                        sccb_pkg::PickDevWrite: nxt.shift_byte = {nxt.device_address, 1'b0};
                        sccb_pkg::PickRegister: nxt.shift_byte = nxt.register_address;
                        sccb_pkg::PickData:     nxt.shift_byte = nxt.write_data;
                        default:                nxt.shift_byte = {nxt.device_address, 1'b1};
                     endcase
                  end
               end else begin
                  attempts = nxt.attempts_left;
                  if (attempts != '0) begin
                     attempts = attempts - sccb_pkg::LimitWidth'(1);
                  end
                  nxt.attempts_left = attempts;
                  if (nxt.nack_tally == 2'd0 || attempts == '0) begin
                     nxt.step = '0;
                     nxt.bit_cnt = 4'd0;
                     res.done_res = 1'b1;
                  end else begin
                     nxt.nack_tally = 2'd0;
                     nxt.step = sccb_pkg::StepWidth'(1);
                     nxt.bit_cnt = 4'd0;
                  end
               end
            end
         end
      end

      res.nack_count = nxt.nack_tally;
      res.read_result = nxt.received_byte;
   end

endmodule

FILE: rtl/sccb_register_master.sv
// Channel   Role    Payload                                          Transfer when
// req_if    sink    mode, device_address, register_address,          valid && ready
//                   write_data, sda_level (one bus tick per item)
// rsp_if    source  scl, sda_out, sda_drive, busy_res, done_res,     valid && ready
//                   nack_count, read_result (one per request)
// csr_*     write   csr_index 0 attempt_limit, 1 ticks_per_phase     csr_write_enable
//
// Each request transfer yields its response in the next cycle; one request per cycle is sustained
// unless rsp_if stalls. Sequencer state and response register update together on each transfer.
// Reset returns the sequencer to idle and the registers to a limit of 10 attempts, 1 tick per phase.
// While a response waits on a stalled rsp_if, req_if.ready is low; otherwise it is high.
module sccb_register_master (
   input  logic                                   clock,
   input  logic                                   reset,
   sccb_chan_if.sink                              req_if,
   sccb_chan_if.source                            rsp_if,
   input  logic                                   csr_write_enable,
   input  logic                                   csr_index,
   input  logic [sccb_pkg::CsrWidth-1:0]          csr_write_data
);

   sccb_pkg::state_type state_ff;
   sccb_pkg::state_type state_in;
   sccb_pkg::cfg_type   cfg_ff;
   sccb_pkg::rsp_type   rsp_payload_ff;
   sccb_pkg::rsp_type   rsp_payload_in;
   logic                rsp_valid_ff;
   logic                req_take;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_take = req_if.valid && req_if.ready;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.payload = rsp_payload_ff;

   sccb_step u_step (
      .cur (state_ff),
      .cfg (cfg_ff),
      .req (req_if.payload),
      .nxt (state_in),
      .res (rsp_payload_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cfg_ff.attempt_limit <= sccb_pkg::AttemptLimitReset;
         cfg_ff.ticks_per_phase <= sccb_pkg::TicksPerPhaseReset;
      end else begin
         if (req_take) begin
            state_ff <= state_in;
            rsp_payload_ff <= rsp_payload_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            case (csr_index)
               sccb_pkg::CsrAttemptLimit:
                  cfg_ff.attempt_limit <= csr_write_data[sccb_pkg::LimitWidth-1:0];
               sccb_pkg::CsrTicksPerPhase:
                  cfg_ff.ticks_per_phase <= csr_write_data[sccb_pkg::TimerWidth-1:0];
               default: ;
            endcase
         end
      end
   end

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.step <= sccb_pkg::ReadPlanLength)
      else $error("Sequence step is beyond the read plan.");

   a_idle_counters: assert property (@(posedge clock) disable iff (reset)
      (state_ff.step == '0) |-> (state_ff.bit_cnt == 4'd0 && state_ff.timer == '0))
      else $error("Idle sequencer holds a nonzero bit or phase count.");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.done_res) |-> rsp_payload_ff.busy_res)
      else $error("Done reported on a tick that is not busy.");

   a_idle_pins: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_payload_ff.busy_res) |->
      (rsp_payload_ff.scl && rsp_payload_ff.sda_out && rsp_payload_ff.sda_drive))
      else $error("Bus lines not released high while idle.");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (req_take && rsp_payload_in.done_res) |=> (state_ff.step == '0))
      else $error("Sequencer left running after a finished transfer.");

endmodule

FILE: bench/sccb_register_master_tb.sv
`timescale 1ns / 1ps

module sccb_register_master_tb;

   localparam logic [1:0] ModeUnused = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                          csr_write_enable;
   logic                          csr_index;
   logic [sccb_pkg::CsrWidth-1:0] csr_write_data;

   sccb_chan_if #(.payload_type(sccb_pkg::req_type)) req_if ();
   sccb_chan_if #(.payload_type(sccb_pkg::rsp_type)) rsp_if ();

   sccb_register_master dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   logic [3:0] cfg_attempts;
   logic [9:0] cfg_phase_ticks;
   logic [3:0] bus_step;
   logic [9:0] phase_tick;
   logic [3:0] half_bit;
   logic [7:0] out_byte;
   logic [3:0] tries_left;
   logic [1:0] miss_count;
   logic [7:0] read_back;
   logic [6:0] held_dev;
   logic [7:0] held_reg;
   logic [7:0] held_data;
   logic       held_read;

   sccb_pkg::rsp_type pending_pin_states[$];
   int      bad_fields = 0;
   int      ticks_sent = 0;
   bit      quiet_tail = 1'b0;

   function automatic sccb_pkg::seg_type plan_segment(input logic rd, input int idx);
      sccb_pkg::seg_type seg;
      seg = '{kind: sccb_pkg::SegStart, pick: sccb_pkg::PickDevWrite};
      case (idx)
         1: seg.kind = sccb_pkg::SegSend;
         2, 4, 8: seg.kind = sccb_pkg::SegAck;
         3: begin
            seg.kind = sccb_pkg::SegSend;
            seg.pick = sccb_pkg::PickRegister;
         end
         5: begin
            if (rd) begin
               seg.kind = sccb_pkg::SegStop;
            end else begin
               seg.kind = sccb_pkg::SegSend;
               seg.pick = sccb_pkg::PickData;
            end
         end
         6: begin
            if (rd) seg.kind = sccb_pkg::SegStart;
            else seg.kind = sccb_pkg::SegAck;
         end
         7: begin
            if (rd) begin
               seg.kind = sccb_pkg::SegSend;
               seg.pick = sccb_pkg::PickDevRead;
            end else begin
               seg.kind = sccb_pkg::SegStop;
            end
         end
         9: seg.kind = sccb_pkg::SegGet;
         10: seg.kind = sccb_pkg::SegNack;
         11: seg.kind = sccb_pkg::SegStop;
         default: ;
      endcase
      return seg;
   endfunction

   function automatic void open_segment(input int idx);
      sccb_pkg::seg_type seg;
      seg = plan_segment(held_read, idx);
      bus_step = 4'(idx + 1);
      half_bit = 4'd0;
      phase_tick = 10'd0;
      if (seg.kind == sccb_pkg::SegSend) begin
         case (seg.pick)
            sccb_pkg::PickDevWrite: out_byte = {held_dev, 1'b0};
            sccb_pkg::PickRegister: out_byte = held_reg;
            sccb_pkg::PickData:     out_byte = held_data;
            default:                out_byte = {held_dev, 1'b1};
         endcase
      end
   endfunction

   function automatic sccb_pkg::rsp_type predict_bus_tick(input sccb_pkg::req_type item);
      sccb_pkg::rsp_type pins;
      sccb_pkg::seg_type seg;
      int      idx;
      int      tpp;
      int      span;
      int      plan_len;
      pins = '0;
      pins.scl = 1'b1;
      pins.sda_out = 1'b1;
      pins.sda_drive = 1'b1;
      if (bus_step == 4'd0 &&
          (item.mode == sccb_pkg::ModeWrite || item.mode == sccb_pkg::ModeRead)) begin
         held_read = (item.mode == sccb_pkg::ModeRead);
         held_dev = item.device_address;
         held_reg = item.register_address;
         held_data = item.write_data;
         tries_left = (cfg_attempts != 4'd0) ? cfg_attempts : 4'd1;
         miss_count = 2'd0;
         open_segment(0);
      end
      if (bus_step != 4'd0) begin
         idx = int'(bus_step) - 1;
         seg = plan_segment(held_read, idx);
         tpp = (cfg_phase_ticks != 10'd0) ? int'(cfg_phase_ticks) : 1;
         pins.busy_res = 1'b1;
         case (seg.kind)
            sccb_pkg::SegStart: pins.sda_out = (half_bit == 4'd0);
            sccb_pkg::SegSend: begin
               pins.scl = half_bit[0];
               pins.sda_out = out_byte[7];
            end
            sccb_pkg::SegAck, sccb_pkg::SegGet: begin
               pins.scl = half_bit[0];
               pins.sda_out = 1'b0;
               pins.sda_drive = 1'b0;
            end
            sccb_pkg::SegStop: begin
               pins.scl = (half_bit != 4'd0);
               pins.sda_out = (half_bit != 4'd0);
            end
            default: pins.scl = (half_bit == 4'd2);
         endcase
         if (int'(phase_tick) + 1 < tpp) begin
            phase_tick = phase_tick + 10'd1;
         end else begin
            phase_tick = 10'd0;
            if (seg.kind == sccb_pkg::SegAck && half_bit == 4'd1 && item.sda_level &&
                miss_count != 2'd3)
               miss_count = miss_count + 2'd1;
            if (seg.kind == sccb_pkg::SegSend && half_bit[0])
               out_byte = {out_byte[6:0], 1'b0};
            if (seg.kind == sccb_pkg::SegGet && half_bit[0])
               out_byte = {out_byte[6:0], item.sda_level};
            if (seg.kind == sccb_pkg::SegSend || seg.kind == sccb_pkg::SegGet) span = 16;
            else if (seg.kind == sccb_pkg::SegNack) span = 4;
            else span = 2;
            plan_len = held_read ? int'(sccb_pkg::ReadPlanLength)
                                 : int'(sccb_pkg::WritePlanLength);
            if (int'(half_bit) + 1 < span) begin
               half_bit = half_bit + 4'd1;
            end else begin
               if (seg.kind == sccb_pkg::SegGet) read_back = out_byte;
               if (idx + 1 < plan_len) begin
                  open_segment(idx + 1);
               end else begin
                  if (tries_left != 4'd0) tries_left = tries_left - 4'd1;
                  if (miss_count == 2'd0 || tries_left == 4'd0) begin
                     bus_step = 4'd0;
                     half_bit = 4'd0;
                     pins.done_res = 1'b1;
                  end else begin
                     miss_count = 2'd0;
                     open_segment(0);
                  end
               end
            end
         end
      end
      pins.nack_count = miss_count;
      pins.read_result = read_back;
      return pins;
   endfunction

   function automatic sccb_pkg::req_type random_tick(input logic [1:0] mode, input logic sda);
      sccb_pkg::req_type item;
      item.mode = mode;
      item.device_address = 7'($urandom_range(0, 127));
      item.register_address = 8'($urandom_range(0, 255));
      item.write_data = 8'($urandom_range(0, 255));
      item.sda_level = sda;
      return item;
   endfunction

   task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         bad_fields++;
         if (bad_fields <= 10)
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      sccb_pkg::rsp_type want;
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_pin_states.size() == 0) begin
            bad_fields++;
            if (bad_fields <= 10)
               $display("%0t: response transfer with nothing outstanding", $time);
         end else begin
            want = pending_pin_states.pop_front();
            check_field("scl", 8'(want.scl), 8'(rsp_if.payload.scl));
            check_field("sda_out", 8'(want.sda_out), 8'(rsp_if.payload.sda_out));
            check_field("sda_drive", 8'(want.sda_drive), 8'(rsp_if.payload.sda_drive));
            check_field("busy_res", 8'(want.busy_res), 8'(rsp_if.payload.busy_res));
            check_field("done_res", 8'(want.done_res), 8'(rsp_if.payload.done_res));
            check_field("nack_count", 8'(want.nack_count), 8'(rsp_if.payload.nack_count));
            check_field("read_result", want.read_result, rsp_if.payload.read_result);
         end
      end
   end

   initial begin
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   task automatic send_tick(input sccb_pkg::req_type item);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      ticks_sent++;
      pending_pin_states.push_back(predict_bus_tick(item));
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (pending_pin_states.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_bus_config(input int attempts, input int ticks);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_index <= sccb_pkg::CsrAttemptLimit;
      csr_write_data <= sccb_pkg::CsrWidth'(attempts);
      @(posedge clock);
      cfg_attempts = 4'(attempts);
      csr_index <= sccb_pkg::CsrTicksPerPhase;
      csr_write_data <= sccb_pkg::CsrWidth'(ticks);
      @(posedge clock);
      cfg_phase_ticks = 10'(ticks);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_transaction(input logic [1:0] start_mode, input logic [6:0] dev,
                                  input logic [7:0] reg_addr, input logic [7:0] data,
                                  input int nack_odds, input logic [7:0] read_byte,
                                  input bit clutter);
      sccb_pkg::req_type item;
      sccb_pkg::seg_type seg;
      logic    sda;
      item.mode = start_mode;
      item.device_address = dev;
      item.register_address = reg_addr;
      item.write_data = data;
      item.sda_level = 1'($urandom_range(0, 1));
      send_tick(item);
      while (bus_step != 4'd0) begin
         seg = plan_segment(held_read, int'(bus_step) - 1);
         if (seg.kind == sccb_pkg::SegGet) sda = read_byte[3'd7 - half_bit[3:1]];
         else if (nack_odds == 0) sda = 1'b0;
         else sda = ($urandom_range(1, nack_odds) == 1);
         send_tick(random_tick(clutter ? 2'($urandom_range(0, 3)) : sccb_pkg::ModeTick, sda));
      end
   endtask

   task automatic test_idle_ticks();
      send_tick('{mode: sccb_pkg::ModeTick, device_address: 7'h7F, register_address: 8'hFF,
                  write_data: 8'hFF, sda_level: 1'b1});
      send_tick('{mode: sccb_pkg::ModeTick, device_address: 7'h00, register_address: 8'h00,
                  write_data: 8'h00, sda_level: 1'b0});
      send_tick('{mode: ModeUnused, device_address: 7'h7F, register_address: 8'hFF,
                  write_data: 8'hFF, sda_level: 1'b1});
      send_tick('{mode: ModeUnused, device_address: 7'h00, register_address: 8'h00,
                  write_data: 8'h00, sda_level: 1'b0});
   endtask

   task automatic test_register_write();
      run_transaction(sccb_pkg::ModeWrite, 7'h7F, 8'hFF, 8'hFF, 0, 8'h00, 1'b0);
      run_transaction(sccb_pkg::ModeWrite, 7'h00, 8'h00, 8'h00, 0, 8'h00, 1'b0);
      run_transaction(sccb_pkg::ModeWrite, 7'h2A, 8'h5A, 8'hA5, 0, 8'h00, 1'b0);
   endtask

   task automatic test_register_read();
      run_transaction(sccb_pkg::ModeRead, 7'h55, 8'h0F, 8'h00, 0, 8'hFF, 1'b0);
      run_transaction(sccb_pkg::ModeRead, 7'h2A, 8'hF0, 8'hFF, 0, 8'h00, 1'b0);
      run_transaction(sccb_pkg::ModeRead, 7'h7F, 8'hFF, 8'h00, 0, 8'h96, 1'b0);
   endtask

   task automatic test_requests_while_busy();
      run_transaction(sccb_pkg::ModeWrite, 7'h12, 8'h34, 8'h56, 0, 8'h00, 1'b1);
      run_transaction(sccb_pkg::ModeRead, 7'h3C, 8'hC3, 8'h00, 0, 8'h69, 1'b1);
   endtask

   // A level of one in every acknowledge slot keeps the tally at its ceiling on every attempt.
   task automatic test_nack_retries();
      set_bus_config(3, 1);
      run_transaction(sccb_pkg::ModeWrite, 7'h21, 8'h43, 8'h65, 1, 8'h00, 1'b0);
      run_transaction(sccb_pkg::ModeRead, 7'h42, 8'h86, 8'h00, 1, 8'h5A, 1'b0);
      set_bus_config(15, 1);
      run_transaction(sccb_pkg::ModeWrite, 7'h0F, 8'h1E, 8'h2D, 3, 8'h00, 1'b0);
      run_transaction(sccb_pkg::ModeRead, 7'h70, 8'hE1, 8'h00, 3, 8'hC3, 1'b1);
   endtask

   task automatic test_zero_settings();
      set_bus_config(0, 0);
      run_transaction(sccb_pkg::ModeWrite, 7'h11, 8'h22, 8'h33, 1, 8'h00, 1'b0);
      run_transaction(sccb_pkg::ModeRead, 7'h44, 8'h55, 8'h00, 0, 8'h3C, 1'b0);
   endtask

   task automatic test_slowest_phase();
      set_bus_config(15, 4);
      run_transaction(sccb_pkg::ModeWrite, 7'h5D, 8'hB7, 8'h6E, 0, 8'h00, 1'b0);
   endtask

   task automatic test_random_traffic();
      int stop_at;
      int nack_odds;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_bus_config(10, 1);
            1: set_bus_config(1, 1);
            2: set_bus_config(15, 2);
            3: set_bus_config(2, 3);
            4: set_bus_config(5, 1);
            default: begin
               set_bus_config($urandom_range(1, 15), 1);
               quiet_tail = 1'b1;
            end
         endcase
         stop_at = ticks_sent + 100;
         while (ticks_sent < stop_at) begin
            if ($urandom_range(0, 7) == 0) begin
               send_tick(random_tick($urandom_range(0, 1) ? sccb_pkg::ModeTick : ModeUnused,
                                     1'($urandom_range(0, 1))));
            end else begin
               case ($urandom_range(0, 3))
                  0: nack_odds = 0;
                  1: nack_odds = 2;
                  2: nack_odds = 8;
                  default: nack_odds = 24;
               endcase
               run_transaction($urandom_range(0, 1) ? sccb_pkg::ModeWrite : sccb_pkg::ModeRead,
                               7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), nack_odds,
                               8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               if (!quiet_tail && $urandom_range(0, 5) == 0) drain_results();
            end
         end
      end
   endtask

   initial begin
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= sccb_pkg::CsrAttemptLimit;
      csr_write_data <= '0;
      cfg_attempts = sccb_pkg::AttemptLimitReset;
      cfg_phase_ticks = sccb_pkg::TicksPerPhaseReset;
      bus_step = 4'd0;
      phase_tick = 10'd0;
      half_bit = 4'd0;
      out_byte = 8'd0;
      tries_left = 4'd0;
      miss_count = 2'd0;
      read_back = 8'd0;
      held_dev = 7'd0;
      held_reg = 8'd0;
      held_data = 8'd0;
      held_read = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_idle_ticks();
      test_register_write();
      test_register_read();
      test_requests_while_busy();
      test_nack_retries();
      test_zero_settings();
      test_slowest_phase();
      test_random_traffic();

      drain_results();
      if (bad_fields == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: files.f
rtl/sccb_pkg.sv
rtl/sccb_chan_if.sv
rtl/sccb_step.sv
rtl/sccb_register_master.sv
bench/sccb_register_master_tb.sv
